// File: hw/rtl/met_pkg.sv
// ---------------------------------------------------------------------------
// met_pkg
// Shared types and constants of the escape-time pixel block.
// ---------------------------------------------------------------------------
package met_pkg;

	localparam int COL_W  = 9;
	localparam int ROW_W  = 8;
	localparam int ITER_W = 10;
	localparam int SHADE_W = 8;
	localparam int SHIFT_W = 5;
	localparam int STEP_W = 31;
	localparam int COORD_W = 32;
	localparam int ZW = 48;
	localparam int SQW = 96;
	localparam int DIV_NW = 18;

	localparam logic [SQW:0] ESC_BOUND = 97'(100000) << 56;
	localparam logic [SHADE_W-1:0] FULL_SHADE = 8'd255;

	// register indexes
	localparam logic [2:0] REG_X_LOWER = 3'd0;
	localparam logic [2:0] REG_Y_LOWER = 3'd1;
	localparam logic [2:0] REG_STEP    = 3'd2;
	localparam logic [2:0] REG_LIMIT   = 3'd3;
	localparam logic [2:0] REG_SEP     = 3'd4;

	localparam logic [COORD_W-1:0] X_LOWER_RST = 32'hDA00_0000;
	localparam logic [COORD_W-1:0] Y_LOWER_RST = 32'hEE00_0000;
	localparam logic [STEP_W-1:0]  STEP_RST    = 31'd2516582;
	localparam logic [ITER_W-1:0]  LIMIT_RST   = 10'd24;
	localparam logic [SHIFT_W-1:0] SEP_RST     = 5'd0;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [ZW-1:0] cx;
		logic [ZW-1:0] cy;
	} met_item_t;

endpackage

// File: hw/rtl/met_if.sv
// ---------------------------------------------------------------------------
// met_if
// Pixel and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface met_px_if;
	import met_pkg::*;
	logic valid;
	logic ready;
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row;
	modport source (output valid, column, row, input ready);
	modport sink (input valid, column, row, output ready);
endinterface

interface met_res_if;
	import met_pkg::*;
	logic valid;
	logic ready;
	logic [COL_W-1:0] out_column;
	logic [ROW_W-1:0] out_row;
	logic escaped;
	logic [ITER_W-1:0] iterations;
	logic [SHADE_W-1:0] intensity;
	logic [SHIFT_W-1:0] stereo_shift;
	modport source (output valid, out_column, out_row, escaped, iterations, intensity,
		stereo_shift, input ready);
	modport sink (input valid, out_column, out_row, escaped, iterations, intensity,
		stereo_shift, output ready);
endinterface

// File: hw/rtl/met_front.sv
// ---------------------------------------------------------------------------
// met_front
// Takes a pixel word, wraps column and row, and forms the point c.
// ---------------------------------------------------------------------------
module met_front #(
	parameter int MaxCols = 512,
	parameter int MaxRows = 256
) (
	input  logic clk,
	input  logic arst_n,
	met_px_if.sink pix,
	input  logic [met_pkg::COORD_W-1:0] x_lower,
	input  logic [met_pkg::COORD_W-1:0] y_lower,
	input  logic [met_pkg::STEP_W-1:0] pixel_step,
	output logic push_valid,
	input  logic push_ready,
	output met_pkg::met_item_t push_item
);
	import met_pkg::*;

	logic v_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_red;
	logic [ROW_W-1:0] row_red;
	logic [39:0] xprod;
	logic [39:0] yprod;

	// wrap by repeated conditional subtraction of shifted moduli
	always_comb begin
		col_red = pix.column;
		for (int s = COL_W - 1; s >= 0; s--) begin
			if (int'(col_red) >= (MaxCols << s)) begin
				col_red = col_red - COL_W'(MaxCols << s);
			end
		end
		row_red = pix.row;
		for (int s = ROW_W - 1; s >= 0; s--) begin
			if (int'(row_red) >= (MaxRows << s)) begin
				row_red = row_red - ROW_W'(MaxRows << s);
			end
		end
	end

	assign pix.ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix.ready) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			col_s1 <= col_red;
			row_s1 <= row_red;
		end
	end

	assign xprod = 40'(col_s1) * 40'(pixel_step);
	assign yprod = 40'(row_s1) * 40'(pixel_step);

	assign push_valid = v_s1;
	assign push_item.col = col_s1;
	assign push_item.row = row_s1;
	assign push_item.cx = {{(ZW-COORD_W){x_lower[COORD_W-1]}}, x_lower} + {8'b0, xprod};
	assign push_item.cy = {{(ZW-COORD_W){y_lower[COORD_W-1]}}, y_lower} + {8'b0, yprod};

endmodule

// File: hw/rtl/met_queue.sv
// ---------------------------------------------------------------------------
// met_queue
// Two-entry queue between the pixel front end and the iteration engine.
// ---------------------------------------------------------------------------
module met_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  met_pkg::met_item_t push_item,
	output logic pop_valid,
	input  logic pop_ready,
	output met_pkg::met_item_t pop_item
);
	import met_pkg::*;

	met_item_t ent_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_item = ent_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= push_item;
	end

endmodule

// File: hw/rtl/met_div.sv
// ---------------------------------------------------------------------------
// met_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module met_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [met_pkg::DIV_NW-1:0] num,
	input  logic [met_pkg::ITER_W-1:0] den,
	output logic done,
	output logic [met_pkg::DIV_NW-1:0] quo
);
	import met_pkg::*;

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [ITER_W-1:0] den_q;
	logic [ITER_W-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [ITER_W:0] rem_sh;
	logic fit;

	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign fit = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 5'(DIV_NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fit ? ITER_W'(rem_sh - {1'b0, den_q}) : rem_sh[ITER_W-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// File: hw/rtl/met_back.sv
// ---------------------------------------------------------------------------
// met_back
// Iteration engine: z = z*z + c on a shared 48x16 multiplier, then shading.
// ---------------------------------------------------------------------------
module met_back #(
	parameter int IterMax = 1023
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  met_pkg::met_item_t pop_item,
	input  logic [met_pkg::ITER_W-1:0] iteration_limit,
	input  logic [met_pkg::SHIFT_W-1:0] stereo_half_sep,
	met_res_if.source res
);
	import met_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_DIV1 = 3'd4;
	localparam logic [2:0] S_DIV2 = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [1:0] P_XY = 2'd0;
	localparam logic [1:0] P_XX = 2'd1;
	localparam logic [1:0] P_YY = 2'd2;

	logic [2:0] state_q;
	logic [1:0] sel_q;
	logic [1:0] cnt_q;
	logic [ITER_W-1:0] k_q;
	logic [ITER_W-1:0] lim_q;
	logic [ITER_W-1:0] lim_c;
	logic [ZW-1:0] cx_q, cy_q, x_q, y_q;
	logic [SQW-1:0] xx_q, yy_q, acc_q;
	logic [SQW:0] xy_q;
	logic [63:0] prod_s1;
	logic [ZW-1:0] ma, mb, mx, my;
	logic [15:0] slice;
	logic [SQW-1:0] add_term, acc_next;
	logic [SQW:0] diff, mag_sum;
	logic go_q;
	logic div_done;
	logic [DIV_NW-1:0] div_num, div_quo;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic esc_q;
	logic [SHADE_W-1:0] shade_q;
	logic [SHIFT_W-1:0] shift_q;

	assign lim_c = (int'(iteration_limit) > IterMax) ? ITER_W'(IterMax) : iteration_limit;

	assign mx = x_q[ZW-1] ? -x_q : x_q;
	assign my = y_q[ZW-1] ? -y_q : y_q;
	assign ma = (sel_q == P_YY) ? my : mx;
	assign mb = (sel_q == P_XX) ? mx : my;

	always_comb begin
		case (cnt_q)
			2'd0: slice = mb[15:0];
			2'd1: slice = mb[31:16];
			default: slice = mb[47:32];
		endcase
		case (cnt_q)
			2'd1: add_term = {32'b0, prod_s1};
			2'd2: add_term = {16'b0, prod_s1, 16'b0};
			2'd3: add_term = {prod_s1, 32'b0};
			default: add_term = '0;
		endcase
	end

	assign acc_next = acc_q + add_term;
	assign diff = {1'b0, xx_q} - {1'b0, yy_q};
	assign mag_sum = {1'b0, xx_q} + {1'b0, yy_q};
	assign pop_ready = state_q == S_IDLE;
	assign div_num = (state_q == S_DIV1) ? DIV_NW'(k_q) * DIV_NW'(255)
		: DIV_NW'(stereo_half_sep) * DIV_NW'(lim_q - k_q);

	met_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(go_q),
		.num(div_num),
		.den(lim_q),
		.done(div_done),
		.quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= P_XY;
			cnt_q <= '0;
			go_q <= 1'b0;
		end else begin
			// start the divider on escape and again for the stereo shift
			go_q <= ((state_q == S_CMP) && (mag_sum > ESC_BOUND))
				|| ((state_q == S_DIV1) && div_done);
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						sel_q <= P_XY;
						cnt_q <= '0;
						state_q <= (lim_c == '0) ? S_OUT : S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						case (sel_q)
							P_XY: state_q <= S_UPD;
							P_XX: begin
								sel_q <= P_YY;
							end
							default: state_q <= S_CMP;
						endcase
					end
				end
				S_UPD: begin
					sel_q <= P_XX;
					state_q <= S_MUL;
				end
				S_CMP: begin
					sel_q <= P_XY;
					if (mag_sum > ESC_BOUND) begin
						state_q <= S_DIV1;
					end else if (k_q + 10'd1 == lim_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				col_q <= pop_item.col;
				row_q <= pop_item.row;
				cx_q <= pop_item.cx;
				cy_q <= pop_item.cy;
				lim_q <= lim_c;
				x_q <= '0;
				y_q <= '0;
				xx_q <= '0;
				yy_q <= '0;
				k_q <= '0;
				esc_q <= 1'b0;
				shade_q <= FULL_SHADE;
				shift_q <= '0;
			end
			S_MUL: begin
				prod_s1 <= ma * {32'b0, slice};
				acc_q <= (cnt_q == 2'd0) ? '0 : acc_next;
				if (cnt_q == 2'd3) begin
					case (sel_q)
						P_XY: xy_q <= (x_q[ZW-1] ^ y_q[ZW-1]) ? -{1'b0, acc_next}
							: {1'b0, acc_next};
						P_XX: xx_q <= acc_next;
						default: yy_q <= acc_next;
					endcase
				end
			end
			S_UPD: begin
				// floor shift of the exact value, then wrap to 48 bits
				x_q <= diff[75:28] + cx_q;
				y_q <= xy_q[74:27] + cy_q;
			end
			S_CMP: begin
				if (mag_sum > ESC_BOUND) begin
					esc_q <= 1'b1;
				end else begin
					k_q <= k_q + 10'd1;
				end
			end
			S_DIV1: begin
				if (div_done) shade_q <= div_quo[SHADE_W-1:0];
			end
			S_DIV2: begin
				if (div_done) shift_q <= div_quo[SHIFT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign res.valid = state_q == S_OUT;
	assign res.out_column = col_q;
	assign res.out_row = row_q;
	assign res.escaped = esc_q;
	assign res.iterations = k_q;
	assign res.intensity = shade_q;
	assign res.stereo_shift = shift_q;

`ifndef SYNTHESIS
	a_inside_shade: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.escaped) |-> (res.intensity == FULL_SHADE && res.stereo_shift == '0))
		else $error("non-escaped word with shading");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_UPD || state_q == S_CMP) |-> (k_q < lim_q))
		else $error("iteration count past limit");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider done outside shading");
	a_go_enter: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider start outside shading");
`endif

endmodule

// File: hw/rtl/mandelbrot_escape_time_pixel_top.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time evaluation of one pixel with register port.
// ---------------------------------------------------------------------------
// path: front register and queue, then the iteration loop and the output state,
// plus, on escape, the two shading divisions in turn on one divider
// throughput: one pixel per engine run, taken only after the last result is taken;
// the 48x16 multiplier's 3 passes per product and 3 products per iteration set it
// reset: registers take their default values, queue and engine empty
module mandelbrot_escape_time_pixel_top #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS = 256,
	parameter int ITER_LIMIT_MAX = 1023
) (
	input  logic clk,
	input  logic arst_n,
	met_px_if.sink pix,
	met_res_if.source res,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import met_pkg::*;

	logic [COORD_W-1:0] x_lower_q, y_lower_q;
	logic [STEP_W-1:0] step_q;
	logic [ITER_W-1:0] limit_q;
	logic [SHIFT_W-1:0] sep_q;
	logic wr_en;
	logic push_valid, push_ready, pop_valid, pop_ready;
	met_item_t push_item, pop_item;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lower_q <= X_LOWER_RST;
			y_lower_q <= Y_LOWER_RST;
			step_q <= STEP_RST;
			limit_q <= LIMIT_RST;
			sep_q <= SEP_RST;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_X_LOWER: x_lower_q <= pwdata;
				REG_Y_LOWER: y_lower_q <= pwdata;
				REG_STEP: step_q <= pwdata[STEP_W-1:0];
				REG_LIMIT: limit_q <= pwdata[ITER_W-1:0];
				REG_SEP: sep_q <= pwdata[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_X_LOWER: prdata = x_lower_q;
			REG_Y_LOWER: prdata = y_lower_q;
			REG_STEP: prdata = {1'b0, step_q};
			REG_LIMIT: prdata = {22'b0, limit_q};
			REG_SEP: prdata = {27'b0, sep_q};
			default: prdata = '0;
		endcase
	end

	met_front #(.MaxCols(MAX_COLUMNS), .MaxRows(MAX_ROWS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.x_lower(x_lower_q),
		.y_lower(y_lower_q),
		.pixel_step(step_q),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	met_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	met_back #(.IterMax(ITER_LIMIT_MAX)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.iteration_limit(limit_q),
		.stereo_half_sep(sep_q),
		.res(res)
	);

endmodule
